### design/ppld_pkg.sv
package ppld_pkg;

    // pull applied to member pins
    typedef enum logic [1:0] {
        PH_FLOAT = 2'd0,
        PH_DOWN  = 2'd1,
        PH_UP    = 2'd2
    } phase_t;

    // per-pin verdict codes
    localparam logic [1:0] VERDICT_UNDEF   = 2'd0;
    localparam logic [1:0] VERDICT_OPEN    = 2'd1;
    localparam logic [1:0] VERDICT_SHORT_GND = 2'd2;
    localparam logic [1:0] VERDICT_SHORT_VCC = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIN_MASK     = 2'd2;

    localparam int unsigned SETTLE_W  = 16;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned ROUNDS_W  = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 17'h1FFFF;
    localparam logic [SETTLE_W-1:0]  SETTLE_RESET    = 16'd100;
    localparam logic [7:0]           PIN_MASK_RESET  = 8'hFF;

    // sequencer to lane control word
    typedef struct packed {
        logic capture_down;
        logic capture_up;
        logic classify;
    } ppld_ctl_t;

endpackage

### design/ppld_lane.sv
module ppld_lane
    import ppld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       level,
    input  logic       member,
    input  ppld_ctl_t  ctl,
    output logic [1:0] verdict_next,
    output logic       changed
);

    logic       down_reg, down_next;
    logic       up_reg, up_next;
    logic [1:0] verdict_reg;
    logic [1:0] verdict_calc;

    always_comb
    begin
        down_next = (ctl.capture_down && member) ? level : down_reg;
        up_next   = (ctl.capture_up && member) ? level : up_reg;

        // high under pull-down wins, then low under pull-up
        if (down_next)
        begin
            verdict_calc = VERDICT_SHORT_VCC;
        end
        else if (!up_next)
        begin
            verdict_calc = VERDICT_SHORT_GND;
        end
        else
        begin
            verdict_calc = VERDICT_OPEN;
        end

        if (ctl.classify && member)
        begin
            verdict_next = verdict_calc;
            changed      = (verdict_calc != verdict_reg);
        end
        else
        begin
            verdict_next = verdict_reg;
            changed      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg    <= 1'b0;
            up_reg      <= 1'b0;
            verdict_reg <= VERDICT_UNDEF;
        end
        else
        begin
            down_reg    <= down_next;
            up_reg      <= up_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

### design/ppld_seq.sv
module ppld_seq
    import ppld_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [SETTLE_W-1:0] settle_ticks,
    output ppld_ctl_t           ctl,
    output phase_t              phase_next,
    output logic                switched,
    output logic [ROUNDS_W-1:0] rounds_next
);

    phase_t               phase_reg;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic [ROUNDS_W-1:0]  rounds_reg;
    logic                 settled;

    always_comb
    begin
        elapsed_inc  = (elapsed_reg < ELAPSED_MAX) ? (elapsed_reg + 1'b1) : elapsed_reg;
        settled      = (elapsed_inc > {1'b0, settle_ticks});
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        rounds_next  = rounds_reg;
        switched     = 1'b0;
        ctl          = '0;

        if (go)
        begin
            elapsed_next = elapsed_inc;
            case (phase_reg)
                PH_FLOAT:
                begin
                    if (settled)
                    begin
                        phase_next   = PH_DOWN;
                        elapsed_next = '0;
                        switched     = 1'b1;
                    end
                end
                PH_DOWN:
                begin
                    if (settled)
                    begin
                        phase_next       = PH_UP;
                        elapsed_next     = '0;
                        switched         = 1'b1;
                        ctl.capture_down = 1'b1;
                    end
                end
                PH_UP:
                begin
                    if (settled)
                    begin
                        phase_next     = PH_FLOAT;
                        elapsed_next   = '0;
                        switched       = 1'b1;
                        ctl.capture_up = 1'b1;
                        ctl.classify   = 1'b1;
                        rounds_next    = rounds_reg + 1'b1;
                    end
                end
                default:
                begin
                    // illegal phase code: back to float, count kept
                    phase_next = PH_FLOAT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FLOAT;
            elapsed_reg <= '0;
            rounds_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            rounds_reg  <= rounds_next;
        end
    end

endmodule

### design/pull_probe_load_detector.sv
// pull_probe_load_detector: open / short detection on a group of input pins.
// each input word is one millisecond tick carrying the sampled level of every
// pin. while enabled, the block steps the pull of member pins through float,
// pull-down and pull-up (pull_sel tells the pad logic what to drive). a
// phase ends on the tick where its tick count exceeds settle_ticks; the
// levels of member pins are captured when pull-down and pull-up end. leaving
// pull-up, every member pin is classified: high under pull-down is short to
// supply, else low under pull-up is short to ground, else open. one result
// word comes out for every tick word. throughput is one tick per clock while
// in_stall is low: one lane per pin does the capture and classification in
// parallel, a single sequencer keeps phase, tick count and round count, and
// the result of a tick is registered in a two-entry output buffer (output
// register plus skid register) that keeps ticks flowing while a result
// waits; in_stall rises only when both entries are full. configuration
// writes must be made while no result is outstanding.
module pull_probe_load_detector
    import ppld_pkg::*;
#(
    parameter int unsigned PINS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [((PINS > SETTLE_W) ? PINS : SETTLE_W)-1:0] cfg_data,

    // tick words
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [PINS-1:0]        pin_levels,

    // result words
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             pull_sel,
    output logic                   phase_switched,
    output logic                   verdict_valid,
    output logic [2*PINS-1:0]      pin_verdicts,
    output logic [PINS-1:0]        changed_mask,
    output logic [ROUNDS_W-1:0]    round_count
);

    // result word layout: pull, switched, valid, verdicts, changed, rounds
    localparam int unsigned RES_W = 2 + 1 + 1 + 2*PINS + PINS + ROUNDS_W;

    // configuration registers
    logic                enable_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [PINS-1:0]     pin_mask_reg;

    // handshake
    logic in_fire;
    logic out_fire;
    logic go;

    // sequencer and lanes
    ppld_ctl_t           ctl;
    phase_t              phase_next;
    logic                switched;
    logic [ROUNDS_W-1:0] rounds_next;
    logic [2*PINS-1:0]   verdicts_next;
    logic [PINS-1:0]     changed;
    logic [RES_W-1:0]    result;

    // output buffer
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [RES_W-1:0] out_data_reg, out_data_next;
    logic [RES_W-1:0] skid_data_reg, skid_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            settle_reg   <= SETTLE_RESET;
            pin_mask_reg <= PINS'(PIN_MASK_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:       enable_reg   <= cfg_data[0];
                CFG_SETTLE_TICKS: settle_reg   <= cfg_data[SETTLE_W-1:0];
                CFG_PIN_MASK:     pin_mask_reg <= cfg_data[PINS-1:0];
                default:          ; // unknown index, write dropped
            endcase
        end
    end

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    // a disabled block still answers every tick, with state frozen
    assign go       = in_fire && enable_reg;

    ppld_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .settle_ticks (settle_reg),
        .ctl          (ctl),
        .phase_next   (phase_next),
        .switched     (switched),
        .rounds_next  (rounds_next)
    );

    // one lane per pin
    for (genvar i = 0; i < PINS; i++)
    begin : g_lane
        ppld_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .level        (pin_levels[i]),
            .member       (pin_mask_reg[i]),
            .ctl          (ctl),
            .verdict_next (verdicts_next[2*i +: 2]),
            .changed      (changed[i])
        );
    end

    // merge lane and sequencer outputs into one result word
    assign result = {phase_next, switched, ctl.classify, verdicts_next, changed, rounds_next};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_fire || !out_valid_reg)
        begin
            // output slot free: skid first, else the fresh result
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = result;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            // output held, park the new result
            skid_data_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign {pull_sel, phase_switched, verdict_valid, pin_verdicts, changed_mask,
            round_count} = out_data_reg;

endmodule

### sim/tb_pull_probe_load_detector.sv
`timescale 1ns / 100ps

module tb_pull_probe_load_detector;
    import ppld_pkg::*;

    localparam int unsigned PIN_COUNT    = 8;
    localparam int unsigned CFG_W        = (PIN_COUNT > SETTLE_W) ? PIN_COUNT : SETTLE_W;
    localparam int unsigned CLK_PERIOD   = 4;
    localparam int unsigned MAX_WAIT     = 10;
    localparam int unsigned RANDOM_TICKS = 1000;
    localparam int unsigned DRAIN_CYCLES = 4;

    // index with no register behind it, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // how a pin is wired on the board during random rounds
    typedef enum logic [1:0] {
        WIRE_OPEN  = 2'd0,
        WIRE_GND   = 2'd1,
        WIRE_VCC   = 2'd2,
        WIRE_NOISY = 2'd3
    } pin_wiring_t;

    // one result word as the block should present it
    typedef struct packed {
        phase_t                 pull;
        logic                   switched;
        logic                   round_done;
        logic [2*PIN_COUNT-1:0] verdicts;
        logic [PIN_COUNT-1:0]   changed;
        logic [ROUNDS_W-1:0]    rounds;
    } probe_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIN_COUNT-1:0]   pin_levels;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             pull_sel;
    logic                   phase_switched;
    logic                   verdict_valid;
    logic [2*PIN_COUNT-1:0] pin_verdicts;
    logic [PIN_COUNT-1:0]   changed_mask;
    logic [ROUNDS_W-1:0]    round_count;

    pull_probe_load_detector #(
        .PINS(PIN_COUNT)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pin_levels     (pin_levels),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pull_sel       (pull_sel),
        .phase_switched (phase_switched),
        .verdict_valid  (verdict_valid),
        .pin_verdicts   (pin_verdicts),
        .changed_mask   (changed_mask),
        .round_count    (round_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow copy of the registers, tracked as they are written
    logic                   reg_enable;
    logic [SETTLE_W-1:0]    reg_settle;
    logic [PIN_COUNT-1:0]   reg_mask;

    // shadow copy of the probing sequencer
    phase_t                 probe_phase;
    logic [ELAPSED_W-1:0]   probe_elapsed;
    logic [PIN_COUNT-1:0]   held_down;
    logic [PIN_COUNT-1:0]   held_up;
    logic [2*PIN_COUNT-1:0] probe_verdicts;
    logic [ROUNDS_W-1:0]    probe_rounds;

    probe_word_t pending_words[$];
    pin_wiring_t wiring[PIN_COUNT];

    bit no_idle     = 1'b0;
    int stall_left  = 0;
    int fail_count  = 0;
    int ticks_sent  = 0;
    int words_seen  = 0;
    int rounds_seen = 0;
    int flips_seen  = 0;

    // advance the shadow sequencer by one tick and return the word it yields
    function automatic probe_word_t probe_tick(input logic [PIN_COUNT-1:0] levels);
        probe_word_t          w;
        logic [1:0]           v;
        logic [PIN_COUNT-1:0] changed;
        changed      = '0;
        w.switched   = 1'b0;
        w.round_done = 1'b0;
        if (reg_enable)
        begin
            if (probe_elapsed != ELAPSED_MAX)
                probe_elapsed = probe_elapsed + 1'b1;
            if (probe_elapsed > {1'b0, reg_settle})
            begin
                case (probe_phase)
                    PH_FLOAT:
                        probe_phase = PH_DOWN;
                    PH_DOWN:
                    begin
                        held_down   = (held_down & ~reg_mask) | (levels & reg_mask);
                        probe_phase = PH_UP;
                    end
                    default:
                    begin
                        held_up = (held_up & ~reg_mask) | (levels & reg_mask);
                        // supply short wins over ground short, the rest are open
                        for (int i = 0; i < PIN_COUNT; i++)
                        begin
                            if (reg_mask[i])
                            begin
                                if (held_down[i])
                                    v = VERDICT_SHORT_VCC;
                                else if (!held_up[i])
                                    v = VERDICT_SHORT_GND;
                                else
                                    v = VERDICT_OPEN;
                                if (probe_verdicts[2*i +: 2] != v)
                                    changed[i] = 1'b1;
                                probe_verdicts[2*i +: 2] = v;
                            end
                        end
                        probe_rounds = probe_rounds + 1'b1;
                        w.round_done = 1'b1;
                        probe_phase  = PH_FLOAT;
                    end
                endcase
                probe_elapsed = '0;
                w.switched    = 1'b1;
            end
        end
        w.pull     = probe_phase;
        w.verdicts = probe_verdicts;
        w.changed  = changed;
        w.rounds   = probe_rounds;
        return w;
    endfunction

    // pin levels a board with the current wiring shows under the pull in force
    function automatic logic [PIN_COUNT-1:0] wired_levels();
        logic [PIN_COUNT-1:0] lv;
        lv = PIN_COUNT'($urandom);
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            case (wiring[i])
                WIRE_OPEN:
                begin
                    // an open pin follows the pull, floats at random
                    if (probe_phase == PH_DOWN)
                        lv[i] = 1'b0;
                    else if (probe_phase == PH_UP)
                        lv[i] = 1'b1;
                end
                WIRE_GND: lv[i] = 1'b0;
                WIRE_VCC: lv[i] = 1'b1;
                default:  ;
            endcase
        end
        return lv;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // one tick word: random gap, then hold it until the block takes it
    task automatic send_tick(input logic [PIN_COUNT-1:0] levels);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= levels;
        do
            @(posedge clk);
        while (in_stall);
        pending_words.push_back(probe_tick(levels));
        ticks_sent++;
    endtask

    // stop sending and let every outstanding result drain out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_ENABLE:       reg_enable = data[0];
            CFG_SETTLE_TICKS: reg_settle = data[SETTLE_W-1:0];
            CFG_PIN_MASK:     reg_mask   = data[PIN_COUNT-1:0];
            default:          ;
        endcase
    endtask

    // result side: accept a word, compare against the oldest prediction
    always @(posedge clk)
    begin
        probe_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $error("result word arrived with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("pull_sel", 32'(want.pull), 32'(pull_sel));
                check_field("phase_switched", 32'(want.switched), 32'(phase_switched));
                check_field("verdict_valid", 32'(want.round_done), 32'(verdict_valid));
                check_field("pin_verdicts", 32'(want.verdicts), 32'(pin_verdicts));
                check_field("changed_mask", 32'(want.changed), 32'(changed_mask));
                check_field("round_count", 32'(want.rounds), 32'(round_count));
                if (want.round_done)
                    rounds_seen++;
                flips_seen += $countones(want.changed);
            end
            // back-pressure to hold before the next word
            stall_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // reset values: float phase, nothing captured, all pins undefined
    task automatic test_defaults();
        send_tick('0);
        send_tick('1);
        send_tick(8'h5A);
    endtask

    // shortest settle: every tick switches, so a round takes three words
    task automatic test_full_round();
        wait_idle();
        write_reg(CFG_SETTLE_TICKS, '0);
        // pins 0..2 open, 3..4 shorted to ground, 5..7 shorted to supply
        send_tick(8'h00);
        send_tick(8'hE0);
        send_tick(8'hE7);
        // all pins high under pull-down: every pin ends as supply short, pins 0..4 flip
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'h00);
    endtask

    // non-member pins keep their captured level and verdict
    task automatic test_member_mask();
        wait_idle();
        write_reg(CFG_PIN_MASK, CFG_W'(8'h0F));
        send_tick(8'h55);
        send_tick(8'h00);
        send_tick(8'h00);
    endtask

    // disabled block freezes everything, words still flow
    task automatic test_disable();
        wait_idle();
        write_reg(CFG_ENABLE, '0);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hFF);
        wait_idle();
        write_reg(CFG_ENABLE, CFG_W'(1));
    endtask

    // longest settle holds the phase, dropping it lets the held count through
    task automatic test_long_settle();
        wait_idle();
        write_reg(CFG_SETTLE_TICKS, '1);
        repeat (3) send_tick(8'hFF);
        wait_idle();
        write_reg(CFG_SETTLE_TICKS, CFG_W'(1));
        send_tick(8'h3C);
        send_tick(8'hC3);
    endtask

    // write to the spare index must not touch any register
    task automatic test_unused_index();
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, '1);
        send_tick(8'h0F);
        send_tick(8'hF0);
    endtask

    // random boards and settings, mostly consistent wiring so rounds complete
    task automatic test_random_rounds();
        int random_ticks;
        int chunk_len;
        int pick;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            // full drain between chunks doubles as the sender pause
            wait_idle();
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1)
            begin
                pick = $urandom_range(0, 49);
                if (pick == 0)
                    write_reg(CFG_SETTLE_TICKS, '1);
                else if (pick < 36)
                    write_reg(CFG_SETTLE_TICKS, CFG_W'($urandom_range(0, 3)));
                else if (pick < 46)
                    write_reg(CFG_SETTLE_TICKS, CFG_W'($urandom_range(4, 20)));
                else
                    write_reg(CFG_SETTLE_TICKS, CFG_W'($urandom_range(21, 300)));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 7);
                // upper data bits carry junk, only the low byte is the mask
                write_reg(CFG_PIN_MASK, CFG_W'($urandom));
                if (pick == 1)
                    write_reg(CFG_PIN_MASK, CFG_W'({PIN_COUNT{1'b1}}));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_ENABLE, {(CFG_W - 1)'($urandom),
                                       ($urandom_range(0, 9) != 0)});
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_UNUSED_INDEX, CFG_W'($urandom));
            for (int i = 0; i < PIN_COUNT; i++)
                wiring[i] = pin_wiring_t'($urandom_range(0, 3));
            chunk_len = $urandom_range(20, 60);
            repeat (chunk_len)
            begin
                // a slice of pure noise words among the consistent ones
                if ($urandom_range(0, 9) == 0)
                    send_tick(PIN_COUNT'($urandom));
                else
                    send_tick(wired_levels());
                random_ticks++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        // every input known from time zero, reset held low and released on a falling edge
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ENABLE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        pin_levels = '0;

        reg_enable     = 1'b1;
        reg_settle     = SETTLE_RESET;
        reg_mask       = PIN_MASK_RESET;
        probe_phase    = PH_FLOAT;
        probe_elapsed  = '0;
        held_down      = '0;
        held_up        = '0;
        probe_verdicts = '0;
        probe_rounds   = '0;
        for (int i = 0; i < PIN_COUNT; i++)
            wiring[i] = WIRE_OPEN;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_full_round();
        test_member_mask();
        test_disable();
        test_long_settle();
        test_unused_index();
        test_random_rounds();

        // all sent, wait for the tail of results plus the pipeline latency
        wait_idle();

        $display("covered %0d tick words and %0d result words", ticks_sent, words_seen);
        $display("%0d probing rounds completed, %0d pin verdict changes seen",
                 rounds_seen, flips_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
